/* rtl/bcg_pkg.sv */
package bcg_pkg;

	localparam int CHAN_BITS = 8;
	localparam int COLOR_BITS = 24;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH        = 3'd0,
		REG_HEIGHT       = 3'd1,
		REG_TOP_LEFT     = 3'd2,
		REG_TOP_RIGHT    = 3'd3,
		REG_BOTTOM_LEFT  = 3'd4,
		REG_BOTTOM_RIGHT = 3'd5
	} cfg_reg_t;

	localparam logic [COLOR_BITS-1:0] RST_TOP_LEFT     = 24'h0000FF;
	localparam logic [COLOR_BITS-1:0] RST_TOP_RIGHT    = 24'h00FF00;
	localparam logic [COLOR_BITS-1:0] RST_BOTTOM_LEFT  = 24'hFF0000;
	localparam logic [COLOR_BITS-1:0] RST_BOTTOM_RIGHT = 24'hFFFF00;

endpackage

/* rtl/bcg_lerp.sv */
module bcg_lerp import bcg_pkg::*; #(
	parameter int RB = 13
) (
	input  logic                 clk,
	input  logic [CHAN_BITS-1:0] a,
	input  logic [CHAN_BITS-1:0] b,
	input  logic [RB-1:0]        pos,
	input  logic [RB-1:0]        wgt,
	input  logic [RB-1:0]        res,
	output logic [CHAN_BITS-1:0] q
);

	localparam int DW = CHAN_BITS + RB;
	localparam int NST = CHAN_BITS / 2;

	logic [DW-1:0]        rem_s [0:NST-1];
	logic [RB-1:0]        div_s [0:NST-1];
	logic [CHAN_BITS-1:0] quo_s [0:NST];

	// weighted sum, always below 256 * res
	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(a) * DW'(wgt) + DW'(b) * DW'(pos);
		div_s[0] <= res;
		quo_s[0] <= '0;
	end

	// restoring division, two quotient bits per stage
	for (genvar s = 0; s < NST; s++) begin : g_div
		logic [DW-1:0]        rem_n;
		logic [CHAN_BITS-1:0] quo_n;
		always_comb begin
			logic [DW-1:0] dsh;
			rem_n = rem_s[s];
			quo_n = quo_s[s];
			for (int j = 0; j < 2; j++) begin
				dsh = DW'(div_s[s]) << (CHAN_BITS - 1 - 2 * s - j);
				if (rem_n >= dsh) begin
					rem_n = rem_n - dsh;
					quo_n[CHAN_BITS - 1 - 2 * s - j] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			quo_s[s+1] <= quo_n;
		end
		// the last stage has no use for the remainder
		if (s < NST - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				rem_s[s+1] <= rem_n;
				div_s[s+1] <= div_s[s];
			end
		end
	end

	assign q = quo_s[NST];

endmodule

/* rtl/bilinear_corner_gradient_rgb.sv */
// bilinear corner gradient: one rgb888 color per pixel coordinate
// input: pulse start with pixel_col / pixel_row; busy is always low, so a
// beat can be given in every cycle
// output: done is high for one cycle with pixel_color, once the start
// beat has passed the whole pipeline; one result per cycle sustained,
// results in start order; the receiver cannot stall; the pipeline never holds back
// the pipeline is a coordinate clamp stage, then two blend passes
// (horizontal, vertical) of five stages each: a multiply-add stage and a
// four-stage divider resolving two quotient bits per stage
// config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high; write only while no pixel is in flight
// index 0 width, 1 height, 2..5 corner colors (tl, tr, bl, br)
// a resolution of zero acts as one; coordinates past it saturate
// reset clears the pipeline valid bits and loads 640x480 and the
// default corner colors
module bilinear_corner_gradient_rgb import bcg_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   pixel_col,
	input  logic [COORD_BITS-1:0]   pixel_row,
	output logic                    done,
	output logic [COLOR_BITS-1:0]   pixel_color,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COLOR_BITS-1:0]   cfg_data
);

	localparam int RB = COORD_BITS + 1;
	localparam int LAT = 11;
	localparam int HLAT = 5;

	logic [RB-1:0]         width_q, height_q;
	logic [COLOR_BITS-1:0] tl_q, tr_q, bl_q, br_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RB'(640);
			height_q <= RB'(480);
			tl_q     <= RST_TOP_LEFT;
			tr_q     <= RST_TOP_RIGHT;
			bl_q     <= RST_BOTTOM_LEFT;
			br_q     <= RST_BOTTOM_RIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:        width_q  <= cfg_data[RB-1:0];
				REG_HEIGHT:       height_q <= cfg_data[RB-1:0];
				REG_TOP_LEFT:     tl_q     <= cfg_data;
				REG_TOP_RIGHT:    tr_q     <= cfg_data;
				REG_BOTTOM_LEFT:  bl_q     <= cfg_data;
				REG_BOTTOM_RIGHT: br_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start && !busy};
	end
	assign done = vld_q[LAT-1];

	// clamp stage
	logic [RB-1:0] resx, resy, posx, posy;
	always_comb begin
		resx = (width_q == '0) ? RB'(1) : width_q;
		resy = (height_q == '0) ? RB'(1) : height_q;
		posx = (RB'(pixel_col) >= resx) ? resx - RB'(1) : RB'(pixel_col);
		posy = (RB'(pixel_row) >= resy) ? resy - RB'(1) : RB'(pixel_row);
	end

	logic [RB-1:0] posx_s1, wx_s1, resx_s1, posy_s1, wy_s1, resy_s1;
	always_ff @(posedge clk) begin
		posx_s1 <= posx;
		wx_s1   <= resx - posx;
		resx_s1 <= resx;
		posy_s1 <= posy;
		wy_s1   <= resy - posy;
		resy_s1 <= resy;
	end

	// vertical weights wait for the horizontal pass
	logic [RB-1:0] posy_d [0:HLAT-1];
	logic [RB-1:0] wy_d   [0:HLAT-1];
	logic [RB-1:0] resy_d [0:HLAT-1];
	always_ff @(posedge clk) begin
		posy_d[0] <= posy_s1;
		wy_d[0]   <= wy_s1;
		resy_d[0] <= resy_s1;
		for (int i = 1; i < HLAT; i++) begin
			posy_d[i] <= posy_d[i-1];
			wy_d[i]   <= wy_d[i-1];
			resy_d[i] <= resy_d[i-1];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [CHAN_BITS-1:0] top, bot, fin;
		bcg_lerp #(.RB(RB)) u_top (
			.clk(clk), .a(tl_q[8*c +: 8]), .b(tr_q[8*c +: 8]),
			.pos(posx_s1), .wgt(wx_s1), .res(resx_s1), .q(top)
		);
		bcg_lerp #(.RB(RB)) u_bot (
			.clk(clk), .a(bl_q[8*c +: 8]), .b(br_q[8*c +: 8]),
			.pos(posx_s1), .wgt(wx_s1), .res(resx_s1), .q(bot)
		);
		bcg_lerp #(.RB(RB)) u_ver (
			.clk(clk), .a(top), .b(bot),
			.pos(posy_d[HLAT-1]), .wgt(wy_d[HLAT-1]), .res(resy_d[HLAT-1]), .q(fin)
		);
		assign pixel_color[8*c +: 8] = fin;
	end

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("done without start");
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##11 done) else $error("start lost");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready) else $error("pipeline stalled");

endmodule
